>>> hw/rtl/taetm_pkg.sv
package taetm_pkg;

   // Fixed widths of the position and fraction datapaths.
   localparam int POS_WIDTH = 32;
   localparam int FRAC_BITS = 16;
   localparam int DUR_WIDTH = 32;

   // Derived widths.
   localparam int FRAC_W    = FRAC_BITS + 1;
   localparam int MAG_W     = POS_WIDTH + 1;
   localparam int KMUL_W    = FRAC_BITS + 2;
   localparam int PROD_W    = MAG_W + KMUL_W;
   localparam int CNT_W     = $clog2(FRAC_BITS);
   localparam int CSR_IDX_W = 3;
   localparam int OP_W      = 2;

   // Packed word widths on the stream ports.
   localparam int RSP_BITS   = 2 * POS_WIDTH + 2 + FRAC_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int REQ_DATA_W = 8;

   // Fraction constants with FRAC_BITS fraction bits (Q1.FRAC_BITS one, Q2.FRAC_BITS three).
   localparam logic [FRAC_W-1:0]  FRAC_ONE   = FRAC_W'(1) << FRAC_BITS;
   localparam logic [PROD_W-1:0]  FRAC_HALF  = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic [KMUL_W-1:0]  FRAC_THREE = KMUL_W'(3) << FRAC_BITS;

   // Operation codes of an input word.
   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
   localparam logic [OP_W-1:0] OP_PAUSE = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SLIDER_START = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLIDER_END   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAN_START    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAN_END      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_EASE         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_MASK    = 3'd6;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FRAC,
      ST_DIV,
      ST_SHAPE,
      ST_SQ,
      ST_TMUL,
      ST_EASED,
      ST_SLMUL,
      ST_SLADD,
      ST_PNADD,
      ST_OUT
   } state_type;

endpackage

>>> hw/rtl/two_axis_eased_timed_move_core.sv
// Two-axis timed move with smoothstep easing. Each request word is a start, a
// one millisecond tick or a paused tick, and each produces exactly one response
// word with both axis targets, their issue flags, the time fraction and the run
// done flag (on tlast). A start or an item outside a run goes from acceptance
// straight to the hand-off to the response register. A tick or paused tick in a
// run steps through the fraction check, the one-bit-per-cycle restoring divider
// that forms elapsed/duration, the easing choice, the square, the smoothstep
// product, the cap, the slider scale and target update, the pan scale and target
// update and the hand-off. The square, smoothstep product, slider scale and pan
// scale are four passes through the single shared multiplier, each registered
// before the next. A full fraction skips the divider. Linear motion skips two
// multiplier passes and the cap. A paused tick stops after the fraction. The
// request side is ready only while the sequencer is idle, which it becomes as
// the previous word reaches the response register. The response register lets
// the next word be accepted while the previous response still waits. A response
// that is still waiting holds the sequencer at its hand-off. Configuration
// writes are always accepted and are read live, also by a word in work.
module two_axis_eased_timed_move_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request stream.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata fields from bit 0: slider_arrived, pan_arrived, zero fill.
   input  logic [taetm_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser fields from bit 0: op.
   input  logic [taetm_pkg::OP_W-1:0]           req_tuser,
   // Response stream.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata fields from bit 0: slider_target, slider_issue, pan_target,
   // pan_issue, progress, zero fill.
   output logic [taetm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tlast carries done_res.
   output logic                                 rsp_tlast,
   // Configuration write channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [taetm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [taetm_pkg::DUR_WIDTH-1:0]      csr_data
);
   import taetm_pkg::*;

   // Sequencer and run state.
   state_type               state_ff, state_in;
   logic                    running_ff, running_in;
   logic [DUR_WIDTH-1:0]    elapsed_ff, elapsed_in;
   logic [POS_WIDTH-1:0]    last_sl_ff, last_sl_in;
   logic [POS_WIDTH-1:0]    last_pn_ff, last_pn_in;

   // Configuration registers.
   logic [POS_WIDTH-1:0]    sl_start_ff, sl_start_in;
   logic [POS_WIDTH-1:0]    sl_end_ff, sl_end_in;
   logic [POS_WIDTH-1:0]    pn_start_ff, pn_start_in;
   logic [POS_WIDTH-1:0]    pn_end_ff, pn_end_in;
   logic [DUR_WIDTH-1:0]    dur_ff, dur_in;
   logic                    ease_ff, ease_in;
   logic [1:0]              mask_ff, mask_in;

   // Word being worked on.
   logic [OP_W-1:0]         op_ff, op_in;
   logic                    sl_arr_ff, sl_arr_in;
   logic                    pn_arr_ff, pn_arr_in;

   // Divider and multiplier datapath.
   logic [DUR_WIDTH-1:0]    rem_ff, rem_in;
   logic [FRAC_BITS-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [FRAC_W-1:0]       f_ff, f_in;
   logic [FRAC_W-1:0]       s_ff, s_in;
   logic [PROD_W-1:0]       prod_ff;
   logic                    sl_iss_ff, sl_iss_in;
   logic                    pn_iss_ff, pn_iss_in;
   logic                    done_ff, done_in;

   // Response register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                    rsp_last_ff, rsp_last_in;

   // Combinational helpers.
   logic                    req_fire;
   logic                    csr_fire;
   logic                    sl_mv, pn_mv;
   logic [MAG_W-1:0]        sl_delta, pn_delta;
   logic [MAG_W-1:0]        sl_mag, pn_mag;
   logic [MAG_W-1:0]        mul_a;
   logic [KMUL_W-1:0]       mul_b;
   logic [PROD_W-1:0]       mul_p;
   logic [PROD_W-1:0]       rnd_sum;
   logic [PROD_W-FRAC_BITS-1:0] rnd_q;
   logic [MAG_W:0]          step_ext;
   logic [POS_WIDTH-1:0]    ax_start;
   logic                    ax_neg;
   logic [MAG_W:0]          ax_sum;
   logic [POS_WIDTH-1:0]    ax_tgt;
   logic [DUR_WIDTH:0]      rem_dbl;
   logic                    div_ge;
   logic                    frac_full;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_fire   = csr_valid && csr_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Axis deltas and magnitudes; an axis moves when enabled with start != end.
   assign sl_delta = {sl_end_ff[POS_WIDTH-1], sl_end_ff} - {sl_start_ff[POS_WIDTH-1], sl_start_ff};
   assign pn_delta = {pn_end_ff[POS_WIDTH-1], pn_end_ff} - {pn_start_ff[POS_WIDTH-1], pn_start_ff};
   assign sl_mag   = sl_delta[MAG_W-1] ? (~sl_delta + MAG_W'(1)) : sl_delta;
   assign pn_mag   = pn_delta[MAG_W-1] ? (~pn_delta + MAG_W'(1)) : pn_delta;
   assign sl_mv    = mask_ff[0] && (sl_start_ff != sl_end_ff);
   assign pn_mv    = mask_ff[1] && (pn_start_ff != pn_end_ff);

   // Shared multiplier: operands chosen by the sequencer state.
   always_comb begin
      unique case (state_ff)
         ST_SQ: begin
            mul_a = MAG_W'(f_ff);
            mul_b = KMUL_W'(f_ff);
         end
         ST_TMUL: begin
            mul_a = MAG_W'(rnd_q[FRAC_W-1:0]);
            mul_b = FRAC_THREE - {f_ff, 1'b0};
         end
         ST_SLMUL: begin
            mul_a = sl_mag;
            mul_b = KMUL_W'(s_ff);
         end
         default: begin
            mul_a = pn_mag;
            mul_b = KMUL_W'(s_ff);
         end
      endcase
   end

   assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Round half up of the registered product back to Q1.FRAC_BITS scale.
   assign rnd_sum = prod_ff + FRAC_HALF;
   assign rnd_q   = rnd_sum[PROD_W-1:FRAC_BITS];

   // Shared target adder: start plus or minus the rounded step, wrapped.
   assign ax_start = (state_ff == ST_SLADD) ? sl_start_ff : pn_start_ff;
   assign ax_neg   = (state_ff == ST_SLADD) ? sl_delta[MAG_W-1] : pn_delta[MAG_W-1];
   assign step_ext = {1'b0, rnd_q[MAG_W-1:0]};
   assign ax_sum   = {{2{ax_start[POS_WIDTH-1]}}, ax_start}
                     + (ax_neg ? (~step_ext + (MAG_W+1)'(1)) : step_ext);
   assign ax_tgt   = ax_sum[POS_WIDTH-1:0];

   // One restoring division step.
   assign rem_dbl   = {rem_ff, 1'b0};
   assign div_ge    = rem_dbl >= {1'b0, dur_ff};
   assign frac_full = (dur_ff == '0) || (elapsed_ff >= dur_ff);

   // Next state and datapath control.
   always_comb begin
      state_in    = state_ff;
      running_in  = running_ff;
      elapsed_in  = elapsed_ff;
      last_sl_in  = last_sl_ff;
      last_pn_in  = last_pn_ff;
      sl_start_in = sl_start_ff;
      sl_end_in   = sl_end_ff;
      pn_start_in = pn_start_ff;
      pn_end_in   = pn_end_ff;
      dur_in      = dur_ff;
      ease_in     = ease_ff;
      mask_in     = mask_ff;
      op_in       = op_ff;
      sl_arr_in   = sl_arr_ff;
      pn_arr_in   = pn_arr_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      cnt_in      = cnt_ff;
      f_in        = f_ff;
      s_in        = s_ff;
      sl_iss_in   = sl_iss_ff;
      pn_iss_in   = pn_iss_ff;
      done_in     = done_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      // Register writes.
      if (csr_fire) begin
         unique case (csr_index)
            CSR_SLIDER_START: sl_start_in = csr_data[POS_WIDTH-1:0];
            CSR_SLIDER_END:   sl_end_in   = csr_data[POS_WIDTH-1:0];
            CSR_PAN_START:    pn_start_in = csr_data[POS_WIDTH-1:0];
            CSR_PAN_END:      pn_end_in   = csr_data[POS_WIDTH-1:0];
            CSR_DURATION:     dur_in      = csr_data;
            CSR_EASE:         ease_in     = csr_data[0];
            CSR_AXIS_MASK:    mask_in     = csr_data[1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_tuser;
               sl_arr_in = req_tdata[0];
               pn_arr_in = req_tdata[1];
               sl_iss_in = 1'b0;
               pn_iss_in = 1'b0;
               done_in   = 1'b0;
               if (req_tuser == OP_START) begin
                  // Restart the clock and park moving axes at their start.
                  running_in = 1'b1;
                  elapsed_in = '0;
                  if (sl_mv) last_sl_in = sl_start_ff;
                  if (pn_mv) last_pn_in = pn_start_ff;
                  f_in     = (dur_ff == '0) ? FRAC_ONE : '0;
                  state_in = ST_OUT;
               end else if (running_ff) begin
                  if (req_tuser == OP_TICK && elapsed_ff < dur_ff) begin
                     elapsed_in = elapsed_ff + DUR_WIDTH'(1);
                  end
                  state_in = ST_FRAC;
               end else begin
                  f_in     = '0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_FRAC: begin
            // Full fraction needs no division.
            if (frac_full) begin
               f_in     = FRAC_ONE;
               state_in = ST_SHAPE;
            end else begin
               rem_in   = elapsed_ff;
               quo_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = div_ge ? DUR_WIDTH'(rem_dbl - {1'b0, dur_ff}) : rem_dbl[DUR_WIDTH-1:0];
            quo_in = {quo_ff[FRAC_BITS-2:0], div_ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(FRAC_BITS - 1)) begin
               f_in     = {1'b0, quo_ff[FRAC_BITS-2:0], div_ge};
               state_in = ST_SHAPE;
            end
         end
         ST_SHAPE: begin
            if (op_ff == OP_TICK) begin
               if (ease_ff) begin
                  state_in = ST_SQ;
               end else begin
                  s_in     = f_ff;
                  state_in = ST_SLMUL;
               end
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_SQ: begin
            state_in = ST_TMUL;
         end
         ST_TMUL: begin
            state_in = ST_EASED;
         end
         ST_EASED: begin
            // Smoothstep result, capped at one.
            s_in     = (rnd_q > (PROD_W-FRAC_BITS)'(FRAC_ONE)) ? FRAC_ONE
                                                               : rnd_q[FRAC_W-1:0];
            state_in = ST_SLMUL;
         end
         ST_SLMUL: begin
            state_in = ST_SLADD;
         end
         ST_SLADD: begin
            if (sl_mv && ax_tgt != last_sl_ff) begin
               sl_iss_in  = 1'b1;
               last_sl_in = ax_tgt;
            end
            state_in = ST_PNADD;
         end
         ST_PNADD: begin
            if (pn_mv && ax_tgt != last_pn_ff) begin
               pn_iss_in  = 1'b1;
               last_pn_in = ax_tgt;
            end
            if (f_ff == FRAC_ONE && (!sl_mv || sl_arr_ff) && (!pn_mv || pn_arr_ff)) begin
               done_in    = 1'b1;
               running_in = 1'b0;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Hand the result word over once the response register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({f_ff, pn_iss_ff, last_pn_ff, sl_iss_ff, last_sl_ff});
               rsp_last_in  = done_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b0;
         elapsed_ff   <= '0;
         last_sl_ff   <= '0;
         last_pn_ff   <= '0;
         sl_start_ff  <= '0;
         sl_end_ff    <= '0;
         pn_start_ff  <= '0;
         pn_end_ff    <= '0;
         dur_ff       <= '0;
         ease_ff      <= 1'b1;
         mask_ff      <= 2'b11;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         elapsed_ff   <= elapsed_in;
         last_sl_ff   <= last_sl_in;
         last_pn_ff   <= last_pn_in;
         sl_start_ff  <= sl_start_in;
         sl_end_ff    <= sl_end_in;
         pn_start_ff  <= pn_start_in;
         pn_end_ff    <= pn_end_in;
         dur_ff       <= dur_in;
         ease_ff      <= ease_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      sl_arr_ff   <= sl_arr_in;
      pn_arr_ff   <= pn_arr_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      f_ff        <= f_in;
      s_ff        <= s_in;
      prod_ff     <= mul_p;
      sl_iss_ff   <= sl_iss_in;
      pn_iss_ff   <= pn_iss_in;
      done_ff     <= done_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef SYNTH
   // An accepted word leaves the request side busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request accepted while previous word still in work");

   // A finished run always reports a full fraction.
   a_done_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_data_ff[RSP_BITS-1 -: FRAC_W] == FRAC_ONE))
      else $error("done flagged with incomplete progress");

   // Progress never exceeds one.
   a_progress_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[RSP_BITS-1 -: FRAC_W] <= FRAC_ONE))
      else $error("progress above one");

   // The divider remainder stays below the divisor.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < dur_ff))
      else $error("divider remainder out of range");
`endif

endmodule
